>>> src/blr_pkg.sv
// blr_pkg: shared constants and types for the bidi line reorder unit
// used by blr_ctrl and bidi_line_reorder_unit; no dependencies

package blr_pkg;

    // default sizing
    localparam int MAX_LINE_DEF = 64;
    localparam int TAG_BITS_DEF = 16;

    // fixed field widths
    localparam int LEVEL_W = 7;
    localparam int ODD_W   = 8;

    // lowest odd level code meaning no odd level seen yet
    localparam logic [ODD_W-1:0] NO_ODD = 8'hFF;

    // emit strobe from the sequencer to the output register
    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } t_emit;

endpackage

>>> src/bidi_line_reorder_unit.sv
// bidi_line_reorder_unit: loading takes one request per cycle; each result is read from the
// store (S_OUT_RD) before it leaves, so results leave one at a time and wait on i_stall.
// the line store has one write and two read ports; each swap steps through S_SWAP_RD, S_SWAP_WA and S_SWAP_WB.
// reset clears the control state only; store entries are written before being read.
// depends on blr_pkg, blr_mem, blr_ctrl

module bidi_line_reorder_unit #(
    parameter int MAX_LINE = blr_pkg::MAX_LINE_DEF,
    parameter int TAG_BITS = blr_pkg::TAG_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [TAG_BITS-1:0]         i_box_tag,
    input  logic [blr_pkg::LEVEL_W-1:0] i_embed_level,
    input  logic                        i_line_end,
    // result request channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [TAG_BITS-1:0]         o_out_tag,
    output logic [blr_pkg::LEVEL_W-1:0] o_out_level,
    output logic                        o_out_last,
    output logic                        o_overflow
);

    localparam int LW     = blr_pkg::LEVEL_W;
    localparam int IDX_W  = $clog2(MAX_LINE);
    localparam int WORD_W = TAG_BITS + LW;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [IDX_W-1:0]  w_raddr_a;
    logic [IDX_W-1:0]  w_raddr_b;
    logic [WORD_W-1:0] w_rdata_a;
    logic [WORD_W-1:0] w_rdata_b;
    blr_pkg::t_emit    w_emit;
    logic              w_out_free;

    logic              r_valid;
    logic [TAG_BITS-1:0] r_tag;
    logic [LW-1:0]     r_level;
    logic              r_last;
    logic              r_ovf;

    // line store
    blr_mem #(
        .DEPTH (MAX_LINE),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // load, reorder and emit sequencer
    blr_ctrl #(
        .MAX_LINE (MAX_LINE),
        .TAG_BITS (TAG_BITS),
        .IDX_W    (IDX_W),
        .WORD_W   (WORD_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_box_tag     (i_box_tag),
        .i_embed_level (i_embed_level),
        .i_line_end    (i_line_end),
        .o_we          (w_we),
        .o_waddr       (w_waddr),
        .o_wdata       (w_wdata),
        .o_raddr_a     (w_raddr_a),
        .o_raddr_b     (w_raddr_b),
        .i_rdata_a     (w_rdata_a),
        .i_rdata_b     (w_rdata_b),
        .o_emit        (w_emit),
        .i_out_free    (w_out_free)
    );

    assign w_out_free = !r_valid || !i_stall;

    // output register, valid part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output register, payload part
    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_tag   <= w_rdata_a[WORD_W-1:LW];
            r_level <= w_rdata_a[LW-1:0];
            r_last  <= w_emit.last;
            r_ovf   <= w_emit.ovf;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_tag   = r_tag;
    assign o_out_level = r_level;
    assign o_out_last  = r_last;
    assign o_overflow  = r_ovf;

endmodule

>>> src/blr_mem.sv
// blr_mem: line store, one write port and two registered read ports
// no package dependencies; instantiated by bidi_line_reorder_unit

module blr_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 23
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two read ports, registered
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> src/blr_ctrl.sv
// blr_ctrl: load, rule L2 run reversal and emit sequencer over the line store
// depends on blr_pkg; drives the ports of blr_mem

module blr_ctrl #(
    parameter int MAX_LINE = blr_pkg::MAX_LINE_DEF,
    parameter int TAG_BITS = blr_pkg::TAG_BITS_DEF,
    parameter int IDX_W    = $clog2(MAX_LINE),
    parameter int WORD_W   = TAG_BITS + blr_pkg::LEVEL_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [TAG_BITS-1:0]        i_box_tag,
    input  logic [blr_pkg::LEVEL_W-1:0] i_embed_level,
    input  logic                       i_line_end,
    // store ports
    output logic                       o_we,
    output logic [IDX_W-1:0]           o_waddr,
    output logic [WORD_W-1:0]          o_wdata,
    output logic [IDX_W-1:0]           o_raddr_a,
    output logic [IDX_W-1:0]           o_raddr_b,
    input  logic [WORD_W-1:0]          i_rdata_a,
    input  logic [WORD_W-1:0]          i_rdata_b,
    // result side
    output blr_pkg::t_emit             o_emit,
    input  logic                       i_out_free
);

    localparam int LW    = blr_pkg::LEVEL_W;
    localparam int CNT_W = $clog2(MAX_LINE + 1);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_PREP     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_SWAP_RD  = 4'd4;
    localparam logic [3:0] S_SWAP_WA  = 4'd5;
    localparam logic [3:0] S_SWAP_WB  = 4'd6;
    localparam logic [3:0] S_OUT_RD   = 4'd7;
    localparam logic [3:0] S_OUT_HOLD = 4'd8;

    logic [3:0]                r_state,   n_state;
    logic [CNT_W-1:0]          r_count,   n_count;
    logic [LW-1:0]             r_high,    n_high;
    logic [blr_pkg::ODD_W-1:0] r_low_odd, n_low_odd;
    logic                      r_ovf,     n_ovf;
    logic [LW-1:0]             r_lv,      n_lv;
    logic [IDX_W-1:0]          r_ptr,     n_ptr;
    logic [IDX_W-1:0]          r_start,   n_start;
    logic                      r_in_run,  n_in_run;
    logic [IDX_W-1:0]          r_lo,      n_lo;
    logic [IDX_W-1:0]          r_hi,      n_hi;
    logic                      r_tail,    n_tail;
    logic [WORD_W-1:0]         r_hold,    n_hold;

    logic             w_acc;
    logic             w_room;
    logic [CNT_W-1:0] w_cnt_m1;
    logic [IDX_W-1:0] w_last;
    logic             w_at_end;
    logic             w_hit;
    logic             w_pass_done;

    assign w_room   = r_count < CNT_W'(MAX_LINE);
    assign w_acc    = i_valid && (r_state == S_LOAD);
    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_last   = w_cnt_m1[IDX_W-1:0];
    assign w_at_end = (r_ptr == w_last);
    assign w_hit    = i_rdata_a[LW-1:0] >= r_lv;
    assign o_stall  = (r_state != S_LOAD);

    // store address and write selection
    always_comb begin
        o_we      = 1'b0;
        o_waddr   = r_count[IDX_W-1:0];
        o_wdata   = {i_box_tag, i_embed_level};
        o_raddr_a = r_ptr;
        o_raddr_b = r_hi;
        unique case (r_state)
            S_LOAD: begin
                o_we = w_acc && w_room;
            end
            S_SWAP_RD: begin
                o_raddr_a = r_lo;
            end
            S_SWAP_WA: begin
                o_we    = 1'b1;
                o_waddr = r_lo;
                o_wdata = i_rdata_b;
            end
            S_SWAP_WB: begin
                o_we    = 1'b1;
                o_waddr = r_hi;
                o_wdata = r_hold;
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_high      = r_high;
        n_low_odd   = r_low_odd;
        n_ovf       = r_ovf;
        n_lv        = r_lv;
        n_ptr       = r_ptr;
        n_start     = r_start;
        n_in_run    = r_in_run;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_tail      = r_tail;
        n_hold      = r_hold;
        o_emit      = '0;
        w_pass_done = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    if (w_room) begin
                        n_count = r_count + CNT_W'(1);
                        if (i_embed_level > r_high) begin
                            n_high = i_embed_level;
                        end
                        if (i_embed_level[0] && ({1'b0, i_embed_level} < r_low_odd)) begin
                            n_low_odd = {1'b0, i_embed_level};
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_line_end) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_ptr    = '0;
                n_in_run = 1'b0;
                n_lv     = r_high;
                if (r_count < CNT_W'(2) || r_low_odd == blr_pkg::NO_ODD) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // run closed by a lower entry
                if (r_in_run && !w_hit) begin
                    n_lo     = r_start;
                    n_hi     = r_ptr - IDX_W'(1);
                    n_tail   = w_at_end;
                    n_in_run = 1'b0;
                    n_state  = S_SWAP_RD;
                // run closed by the end of the line
                end else if (w_hit && w_at_end) begin
                    n_lo     = r_in_run ? r_start : r_ptr;
                    n_hi     = r_ptr;
                    n_tail   = 1'b1;
                    n_in_run = 1'b0;
                    n_state  = S_SWAP_RD;
                end else if (w_at_end) begin
                    w_pass_done = 1'b1;
                end else begin
                    if (w_hit && !r_in_run) begin
                        n_start  = r_ptr;
                        n_in_run = 1'b1;
                    end
                    n_ptr   = r_ptr + IDX_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SWAP_RD: begin
                if (r_lo < r_hi) begin
                    n_state = S_SWAP_WA;
                end else if (r_tail) begin
                    w_pass_done = 1'b1;
                end else begin
                    n_ptr   = r_ptr + IDX_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SWAP_WA: begin
                n_hold  = i_rdata_a;
                n_state = S_SWAP_WB;
            end
            S_SWAP_WB: begin
                n_lo    = r_lo + IDX_W'(1);
                n_hi    = r_hi - IDX_W'(1);
                n_state = S_SWAP_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.last  = w_at_end;
                    o_emit.ovf   = r_ovf;
                    if (w_at_end) begin
                        n_count   = '0;
                        n_high    = '0;
                        n_low_odd = blr_pkg::NO_ODD;
                        n_ovf     = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_ptr   = r_ptr + IDX_W'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // level pass finished: next lower level or emit
        if (w_pass_done) begin
            n_ptr    = '0;
            n_in_run = 1'b0;
            if (r_lv == r_low_odd[LW-1:0]) begin
                n_state = S_OUT_RD;
            end else begin
                n_lv    = r_lv - LW'(1);
                n_state = S_SCAN_RD;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_high    <= '0;
            r_low_odd <= blr_pkg::NO_ODD;
            r_ovf     <= 1'b0;
            r_lv      <= '0;
            r_ptr     <= '0;
            r_in_run  <= 1'b0;
            r_tail    <= 1'b0;
            r_start   <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_high    <= n_high;
            r_low_odd <= n_low_odd;
            r_ovf     <= n_ovf;
            r_lv      <= n_lv;
            r_ptr     <= n_ptr;
            r_in_run  <= n_in_run;
            r_tail    <= n_tail;
            r_start   <= n_start;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
        end
    end

    // swap holding register
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    // fill count never passes the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LINE))
        else $error("line count beyond store depth");

    // lowest odd level is either none or an odd level no higher than the highest
    a_low_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low_odd == blr_pkg::NO_ODD) || (r_low_odd[0] && r_low_odd <= {1'b0, r_high}))
        else $error("lowest odd level inconsistent");

    // a swap write only happens for a proper pair
    a_swap_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP_WA) |-> (r_lo < r_hi))
        else $error("swap started on a degenerate pair");

    // scan level stays between lowest odd and highest level
    a_scan_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (r_lv >= r_low_odd[LW-1:0] && r_lv <= r_high))
        else $error("scan level out of range");

    // after an emit the sequencer reads the next entry or reopens loading
    a_emit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |=> (r_state == S_LOAD || r_state == S_OUT_RD))
        else $error("unexpected state after emit");

endmodule
